FILE: hw/rtl/spi_slave_shifter_macros.svh
// Assertion macros shared by the RTL of the SPI slave shifter.
// Each macro expands to nothing when ASSERT_OFF is defined.
`ifndef SPI_SLAVE_SHIFTER_MACROS_SVH
`define SPI_SLAVE_SHIFTER_MACROS_SVH

`ifndef ASSERT_OFF

`define SSS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define SSS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SSS_ASSERT(label, clk, rst_n, prop)

`define SSS_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hw/rtl/sss_pkg.sv
package sss_pkg;

	localparam int DATA_W          = 24;
	localparam int WORD_BITS_W     = 5;
	localparam int TIMER_W         = 24;
	localparam int CFG_IDX_W       = 3;
	localparam int SHIFT_WIDTH_DEF = 24;

	localparam logic [WORD_BITS_W-1:0] WORD_BITS_RST    = 5'd8;
	localparam logic [TIMER_W-1:0]     TIMEOUT_RST      = 24'd1000;
	localparam logic                   SEL_AT_START_RST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_PHASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_AT_START = 3'd4;

	typedef enum logic [1:0] {
		CMD_EDGE   = 2'd0,
		CMD_SELECT = 2'd1,
		CMD_HOST   = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              pin_level;
		logic [DATA_W-1:0] host_word;
	} in_item_t;

	typedef struct packed {
		logic              miso_level;
		logic              miso_enable;
		logic              word_done;
		logic [DATA_W-1:0] received_word;
		logic              select_irq;
		logic              timed_out;
	} out_item_t;

	typedef struct packed {
		logic                   clock_phase;
		logic                   lsb_first;
		logic [WORD_BITS_W-1:0] word_bits;
		logic [TIMER_W-1:0]     timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic value;
	} sel_load_t;

endpackage

FILE: hw/rtl/sss_cfg.sv
module sss_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sss_pkg::DATA_W-1:0]      cfg_data,
	output sss_pkg::cfg_t                   cfg,
	output sss_pkg::sel_load_t              sel_load
);
	import sss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_phase   <= 1'b0;
			cfg_q.lsb_first     <= 1'b0;
			cfg_q.word_bits     <= WORD_BITS_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOCK_PHASE: cfg_q.clock_phase   <= cfg_data[0];
				REG_LSB_FIRST:   cfg_q.lsb_first     <= cfg_data[0];
				REG_WORD_BITS:   cfg_q.word_bits     <= cfg_data[WORD_BITS_W-1:0];
				REG_TIMEOUT:     cfg_q.timeout_ticks <= cfg_data[TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg            = cfg_q;
	assign sel_load.load  = cfg_we && (cfg_index == REG_SEL_AT_START);
	assign sel_load.value = cfg_data[0];

endmodule

FILE: hw/rtl/sss_engine.sv
module sss_engine #(
	parameter int SHIFT_WIDTH = sss_pkg::SHIFT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sss_pkg::cfg_t      cfg,
	input  sss_pkg::sel_load_t sel_load,
	input  logic               step,
	input  sss_pkg::in_item_t  item,
	output sss_pkg::out_item_t result
);
	import sss_pkg::*;

	localparam int EW  = $clog2(SHIFT_WIDTH + 1);
	localparam int EBW = (EW > WORD_BITS_W) ? EW : WORD_BITS_W;

	typedef struct packed {
		logic                   selected;
		logic                   trailing_next;
		logic [WORD_BITS_W-1:0] bit_counter;
		logic [SHIFT_WIDTH-1:0] rx_shift;
		logic [SHIFT_WIDTH-1:0] tx_shift;
		logic [SHIFT_WIDTH-1:0] tx_holding;
		logic [SHIFT_WIDTH-1:0] rx_latched;
		logic [TIMER_W-1:0]     timer_left;
		logic                   timer_armed;
		logic                   miso_out;
		logic                   miso_on;
	} state_t;

	state_t st_q;
	state_t nx;
	logic [EBW-1:0]         eff_bits;
	logic [EBW-1:0]         word_bits_ext;
	logic [WORD_BITS_W-1:0] cnt_inc;
	logic [SHIFT_WIDTH-1:0] tx_src;
	logic                   sample;
	logic                   drive;
	logic                   done;
	logic                   sirq;
	logic                   tout;

	assign word_bits_ext = EBW'(cfg.word_bits);

	always_comb begin
		if (cfg.word_bits == '0) begin
			eff_bits = EBW'(1);
		end else if (word_bits_ext > EBW'(SHIFT_WIDTH)) begin
			eff_bits = EBW'(SHIFT_WIDTH);
		end else begin
			eff_bits = word_bits_ext;
		end
	end

	always_comb begin
		nx      = st_q;
		sample  = 1'b0;
		drive   = 1'b0;
		done    = 1'b0;
		sirq    = 1'b0;
		tout    = 1'b0;
		cnt_inc = st_q.bit_counter + WORD_BITS_W'(1);
		tx_src  = st_q.tx_shift;

		case (item.cmd)
			CMD_EDGE: begin
				if (st_q.selected) begin
					nx.trailing_next = !st_q.trailing_next;
					sample           = (st_q.trailing_next == cfg.clock_phase);
					drive            = !sample;
				end
			end
			CMD_SELECT: begin
				sirq = 1'b1;
				if (!item.pin_level) begin
					nx.selected    = 1'b1;
					nx.bit_counter = '0;
					nx.miso_on     = 1'b1;
					drive          = !cfg.clock_phase;
				end else begin
					nx.selected = 1'b0;
					nx.miso_on  = 1'b0;
				end
			end
			CMD_HOST: begin
				nx.tx_holding = SHIFT_WIDTH'(item.host_word);
				drive         = st_q.selected && !cfg.clock_phase;
			end
			CMD_TICK: begin
				if (st_q.timer_armed) begin
					if (st_q.timer_left <= TIMER_W'(1)) begin
						nx.timer_left    = '0;
						nx.timer_armed   = 1'b0;
						nx.trailing_next = 1'b0;
						nx.bit_counter   = '0;
						nx.miso_on       = 1'b0;
						tout             = 1'b1;
					end else begin
						nx.timer_left = st_q.timer_left - TIMER_W'(1);
					end
				end
			end
			default: begin
			end
		endcase

		if (sample) begin
			if (cfg.lsb_first) begin
				nx.rx_shift = {item.pin_level, st_q.rx_shift[SHIFT_WIDTH-1:1]};
			end else begin
				nx.rx_shift = {st_q.rx_shift[SHIFT_WIDTH-2:0], item.pin_level};
			end
			if (EBW'(cnt_inc) == eff_bits) begin
				nx.rx_latched  = nx.rx_shift;
				nx.bit_counter = '0;
				nx.timer_armed = 1'b0;
				done           = 1'b1;
			end else begin
				nx.bit_counter = cnt_inc;
				nx.timer_left  = cfg.timeout_ticks;
				nx.timer_armed = 1'b1;
			end
		end

		if (drive) begin
			if (nx.bit_counter == '0) begin
				tx_src = nx.tx_holding;
			end
			if (cfg.lsb_first) begin
				nx.miso_out = tx_src[0];
				nx.tx_shift = {1'b0, tx_src[SHIFT_WIDTH-1:1]};
			end else begin
				nx.miso_out = tx_src[SHIFT_WIDTH-1];
				nx.tx_shift = {tx_src[SHIFT_WIDTH-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.selected      <= SEL_AT_START_RST;
			st_q.trailing_next <= 1'b0;
			st_q.bit_counter   <= '0;
			st_q.rx_shift      <= '0;
			st_q.tx_shift      <= '0;
			st_q.tx_holding    <= '0;
			st_q.rx_latched    <= '0;
			st_q.timer_left    <= '0;
			st_q.timer_armed   <= 1'b0;
			st_q.miso_out      <= 1'b0;
			st_q.miso_on       <= SEL_AT_START_RST;
		end else if (sel_load.load) begin
			st_q.selected <= sel_load.value;
			st_q.miso_on  <= sel_load.value;
		end else if (step) begin
			st_q <= nx;
		end
	end

	assign result.miso_level    = nx.miso_out;
	assign result.miso_enable   = nx.miso_on;
	assign result.word_done     = done;
	assign result.received_word = DATA_W'(nx.rx_latched);
	assign result.select_irq    = sirq;
	assign result.timed_out     = tout;

endmodule

FILE: hw/rtl/spi_slave_shifter.sv
// SPI slave shift engine with a word length of 1 to SHIFT_WIDTH bits.
// The input channel (in_valid, in_stall, in_data) carries one event per
// beat: a serial clock edge with the MOSI level, a select-line change, a
// new host word to transmit, or a time tick. Every input beat yields
// exactly one output beat (out_valid, out_stall, out_data) with the MISO
// level and enable, the last received word and the per-event flags.
// A beat is registered in an input stage, evaluated against the shifter
// state, and the result is captured in an output register, so out_valid
// rises once the input stage advances into the output register, and the
// result beat is taken when out_stall is low. One beat is taken every cycle
// as long as the output register is free or being emptied.
// When the receiver stalls, the output register holds its beat, the input
// stage holds the next one, and in_stall rises once both are occupied.
// The configuration port writes one register per cycle with cfg_we; the user
// must use it only while no beats are in flight (not enforced). After reset,
// config and shifter state are reset; the block is selected, MISO driver on.
`include "spi_slave_shifter_macros.svh"

module spi_slave_shifter #(
	parameter int SHIFT_WIDTH = sss_pkg::SHIFT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sss_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sss_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sss_pkg::DATA_W-1:0]    cfg_data
);
	import sss_pkg::*;

	cfg_t      cfg;
	sel_load_t sel_load;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t result_s2;
	logic      valid_s2;
	logic      advance;
	logic [2:0] flags_s2;

	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;

	sss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.sel_load  (sel_load)
	);

	sss_engine #(
		.SHIFT_WIDTH (SHIFT_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.sel_load (sel_load),
		.step     (advance),
		.item     (item_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;
	assign flags_s2  = {result_s2.word_done, result_s2.select_irq, result_s2.timed_out};

	`SSS_ASSERT(a_stall_needs_item, clk, arst_n, in_stall |-> valid_s1)
	`SSS_ASSERT_NEVER(a_no_overwrite, clk, arst_n, advance && valid_s2 && out_stall)
	`SSS_ASSERT(a_one_event_flag, clk, arst_n, valid_s2 |-> ($countones(flags_s2) <= 1))
	`SSS_ASSERT(a_timeout_drops_miso, clk, arst_n, (valid_s2 && result_s2.timed_out) |-> !result_s2.miso_enable)

endmodule

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sss_pkg::*;

	localparam int PERIOD = 8;
	localparam int LIMIT = 400000;
	localparam int RAND_ITEMS = 1650;
	localparam int PHASES = 12;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} beat_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [DATA_W-1:0]    val;
		in_item_t             item;
		bit                   typed;
		out_item_t            want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	beat_t     to_send[$];
	out_item_t pending_results[$];
	int        errors = 0;
	int        cycles = 0;
	int        sent = 0;
	logic      quiet = 1'b0;
	int        burst_left = 0;
	int        gap_left = 0;
	logic [15:0] stall_pat = '0;
	logic [3:0]  stall_ph = '0;

	logic                   m_sel, m_trail, m_armed, m_miso, m_en;
	logic [WORD_BITS_W-1:0] m_count;
	logic [DATA_W-1:0]      m_rx, m_tx, m_hold, m_word;
	logic [TIMER_W-1:0]     m_timer;
	logic                   c_phase, c_lsb, c_start;
	logic [WORD_BITS_W-1:0] c_bits;
	logic [TIMER_W-1:0]     c_ticks;

	spi_slave_shifter u_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic void model_reset();
		c_phase = 1'b0;
		c_lsb = 1'b0;
		c_bits = WORD_BITS_RST;
		c_ticks = TIMEOUT_RST;
		c_start = SEL_AT_START_RST;
		m_sel = c_start;
		m_en = c_start;
		m_trail = 1'b0;
		m_count = '0;
		m_rx = '0;
		m_tx = '0;
		m_hold = '0;
		m_word = '0;
		m_timer = '0;
		m_armed = 1'b0;
		m_miso = 1'b0;
	endfunction

	function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		case (idx)
		REG_CLOCK_PHASE: c_phase = val[0];
		REG_LSB_FIRST: c_lsb = val[0];
		REG_WORD_BITS: c_bits = val[WORD_BITS_W-1:0];
		REG_TIMEOUT: c_ticks = val[TIMER_W-1:0];
		REG_SEL_AT_START: begin
			c_start = val[0];
			m_sel = val[0];
			m_en = val[0];
		end
		default: ;
		endcase
	endfunction

	function automatic logic [WORD_BITS_W-1:0] word_len();
		if (c_bits == 0)
			return WORD_BITS_W'(1);
		if (c_bits > DATA_W)
			return WORD_BITS_W'(DATA_W);
		return c_bits;
	endfunction

	function automatic void shift_out();
		if (m_count == 0)
			m_tx = m_hold;
		if (c_lsb) begin
			m_miso = m_tx[0];
			m_tx = m_tx >> 1;
		end else begin
			m_miso = m_tx[DATA_W-1];
			m_tx = m_tx << 1;
		end
	endfunction

	function automatic out_item_t shifter_step(in_item_t ev);
		out_item_t r;
		logic      sample;
		r = '0;
		case (ev.cmd)
		CMD_EDGE: if (m_sel) begin
			sample = m_trail ? c_phase : !c_phase;
			m_trail = !m_trail;
			if (!sample)
				shift_out();
			else begin
				m_rx = c_lsb ? {ev.pin_level, m_rx[DATA_W-1:1]}
					: {m_rx[DATA_W-2:0], ev.pin_level};
				m_count = m_count + 1'b1;
				if (m_count == word_len()) begin
					m_word = m_rx;
					m_count = '0;
					m_armed = 1'b0;
					r.word_done = 1'b1;
				end else begin
					m_timer = c_ticks;
					m_armed = 1'b1;
				end
			end
		end
		CMD_SELECT: begin
			r.select_irq = 1'b1;
			m_sel = !ev.pin_level;
			m_en = !ev.pin_level;
			if (!ev.pin_level) begin
				m_count = '0;
				if (!c_phase)
					shift_out();
			end
		end
		CMD_HOST: begin
			m_hold = ev.host_word;
			if (m_sel && !c_phase)
				shift_out();
		end
		default: if (m_armed) begin
			if (m_timer <= 1) begin
				m_timer = '0;
				m_armed = 1'b0;
				m_trail = 1'b0;
				m_count = '0;
				m_en = 1'b0;
				r.timed_out = 1'b1;
			end else begin
				m_timer = m_timer - 1'b1;
			end
		end
		endcase
		r.miso_level = m_miso;
		r.miso_enable = m_en;
		r.received_word = m_word;
		return r;
	endfunction

	function automatic string show(out_item_t r);
		return $sformatf("miso=%b en=%b done=%b word=%h irq=%b tout=%b", r.miso_level,
			r.miso_enable, r.word_done, r.received_word, r.select_irq, r.timed_out);
	endfunction

	function automatic row_t ev(cmd_t c, logic l, logic [DATA_W-1:0] w);
		row_t r;
		r = '{1'b0, '0, '0, '{c, l, w}, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t ev_is(cmd_t c, logic l, logic [DATA_W-1:0] w, out_item_t want);
		row_t r;
		r = '{1'b0, '0, '0, '{c, l, w}, 1'b1, want};
		return r;
	endfunction

	function automatic row_t reg_wr(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		row_t r;
		r = '{1'b1, idx, val, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] with_junk(logic [DATA_W-1:0] v, int w);
		return (DATA_W'($urandom) << w) | v;
	endfunction

	// A beat is taken when valid is high and stall is low; a stalled beat is held.
	always @(posedge clk) begin
		out_item_t got;
		logic      fire;
		fire = in_valid && !in_stall;
		if (arst_n) begin
			if (fire) begin
				got = shifter_step(in_data);
				pending_results.push_back(to_send[0].typed ? to_send[0].want : got);
				to_send.delete(0);
			end
			if (in_valid && !fire) begin
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (to_send.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= to_send[0].item;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		stall_ph <= stall_ph + 1'b1;
		if (stall_ph == '1 && $urandom_range(0, 3) == 0)
			stall_pat <= $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom);
		out_stall <= !quiet && stall_pat[stall_ph];
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: %s", $time, show(out_data));
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					errors++;
					$display("%0t: mismatch: expected %s, actual %s", $time, show(want),
						show(out_data));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		model_write(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (to_send.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put(cmd_t c, logic l, logic [DATA_W-1:0] w);
		to_send.push_back('{'{c, l, w}, 1'b0, '0});
		sent++;
	endtask

	task automatic tick_run();
		repeat ((c_ticks <= 24) ? $urandom_range(1, c_ticks + 2) : $urandom_range(1, 6))
			put(CMD_TICK, 1'($urandom_range(0, 1)), DATA_W'($urandom));
	endtask

	task automatic set_phase_config(int ph);
		logic [DATA_W-1:0] bits, ticks;
		logic              cp, lsb;
		cp = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
		lsb = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
		case (ph)
		0: begin
			bits = '0;
			ticks = '0;
		end
		1: begin
			bits = DATA_W'(1);
			ticks = '1;
		end
		2: begin
			bits = DATA_W'(DATA_W);
			ticks = DATA_W'(1);
		end
		3: begin
			bits = DATA_W'(31);
			ticks = DATA_W'(TIMEOUT_RST);
		end
		default: begin
			bits = DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
				: $urandom_range(1, DATA_W));
			ticks = DATA_W'(($urandom_range(0, 7) != 0) ? $urandom_range(1, 20)
				: $urandom_range(21, 3000));
		end
		endcase
		write_reg(REG_CLOCK_PHASE, with_junk(DATA_W'(cp), 1));
		write_reg(REG_LSB_FIRST, with_junk(DATA_W'(lsb), 1));
		write_reg(REG_WORD_BITS, with_junk(bits, WORD_BITS_W));
		write_reg(REG_TIMEOUT, ticks);
		write_reg(REG_SEL_AT_START, with_junk(DATA_W'($urandom_range(0, 1)), 1));
		write_reg(CFG_IDX_W'($urandom_range(REG_SEL_AT_START + 1, REG_UNUSED)),
			DATA_W'($urandom));
	endtask

	// Mostly whole frames: optional select and host word, then full words of clock
	// edges with ticks and host words mixed in; the rest is loose noise and abandoned words.
	task automatic random_phase(int budget);
		int stop, len;
		stop = sent + budget;
		while (sent < stop) begin
			if ($urandom_range(0, 3) != 0) begin
				len = 2 * word_len();
				if ($urandom_range(0, 4) != 0)
					put(CMD_SELECT, 1'b0, DATA_W'($urandom));
				if ($urandom_range(0, 1))
					put(CMD_HOST, 1'($urandom_range(0, 1)), DATA_W'($urandom));
				repeat ($urandom_range(1, 3)) begin
					for (int i = 0; i < len; i++) begin
						put(CMD_EDGE, 1'($urandom_range(0, 1)), DATA_W'($urandom));
						if ($urandom_range(0, 11) == 0)
							put(CMD_TICK, 1'($urandom_range(0, 1)), DATA_W'($urandom));
						if ($urandom_range(0, 39) == 0)
							put(CMD_HOST, 1'($urandom_range(0, 1)), DATA_W'($urandom));
					end
					if ($urandom_range(0, 2) == 0)
						put(CMD_HOST, 1'($urandom_range(0, 1)), DATA_W'($urandom));
				end
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, len - 1))
						put(CMD_EDGE, 1'($urandom_range(0, 1)), DATA_W'($urandom));
					tick_run();
				end
				if ($urandom_range(0, 1))
					put(CMD_SELECT, 1'b1, DATA_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 8))
					put(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						DATA_W'($urandom));
				if ($urandom_range(0, 1))
					tick_run();
			end
		end
	endtask

	initial begin
		row_t rows[$];
		int   ph;
		model_reset();
		rows = '{
			ev_is(CMD_TICK, 1'b0, '0, '{1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0}),
			ev_is(CMD_HOST, 1'b0, '1, '{1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0}),
			ev_is(CMD_SELECT, 1'b1, '0, '{1'b1, 1'b0, 1'b0, '0, 1'b1, 1'b0}),
			ev_is(CMD_EDGE, 1'b1, '1, '{1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0}),
			ev_is(CMD_SELECT, 1'b0, '0, '{1'b1, 1'b1, 1'b0, '0, 1'b1, 1'b0}),
			ev_is(CMD_HOST, 1'b1, '0, '{1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0}),
			reg_wr(REG_TIMEOUT, '0),
			ev(CMD_EDGE, 1'b1, '0),
			ev(CMD_EDGE, 1'b0, '0),
			ev_is(CMD_TICK, 1'b0, '0, '{1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b1}),
			ev(CMD_TICK, 1'b1, '1),
			ev(CMD_SELECT, 1'b0, '1),
			reg_wr(REG_WORD_BITS, '0),
			reg_wr(REG_LSB_FIRST, 24'd1),
			ev(CMD_EDGE, 1'b1, '0),
			ev(CMD_EDGE, 1'b0, '0),
			reg_wr(REG_WORD_BITS, 24'd31),
			reg_wr(REG_CLOCK_PHASE, 24'd1),
			reg_wr(REG_UNUSED, '1),
			reg_wr(REG_SEL_AT_START, '0),
			ev(CMD_EDGE, 1'b1, '0),
			ev(CMD_HOST, 1'b0, 24'hA5A5A5),
			ev(CMD_SELECT, 1'b0, '0),
			ev(CMD_EDGE, 1'b1, '0),
			ev(CMD_EDGE, 1'b0, '0),
			ev(CMD_SELECT, 1'b1, '0),
			ev(CMD_TICK, 1'b0, '0),
			reg_wr(REG_SEL_AT_START, 24'd1)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				to_send.push_back('{rows[i].item, rows[i].typed, rows[i].want});
			end
		end
		ph = 0;
		while (sent < RAND_ITEMS) begin
			wait_idle();
			quiet <= ($urandom_range(0, 3) == 0);
			set_phase_config(ph);
			random_phase(RAND_ITEMS / PHASES);
			ph++;
		end
		wait_idle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
